// File: hdl/bptt_pkg.sv
// ----------------------------------------------------------------------------
// Beacon presence table package
// Shared types, request and event codes, and constants of the presence table.
// ----------------------------------------------------------------------------
package bptt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int RESULT_LIMIT      = 16;
	localparam int RM_W              = $clog2(RESULT_LIMIT + 1);

	localparam logic [31:0] ADV_MAGIC   = 32'h4C00_0215;
	localparam logic [4:0]  ADV_LEN     = 5'd25;
	localparam logic [3:0]  TTL_DEFAULT = 4'd3;

	typedef enum logic [1:0] {
		REQ_SCAN_START = 2'd0,
		REQ_ADVERT     = 2'd1,
		REQ_SCAN_END   = 2'd2,
		REQ_UNUSED     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		EV_ENTERED = 2'd0,
		EV_LEFT    = 2'd1,
		EV_DROPPED = 2'd2,
		EV_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic        valid;
		logic        pick;
		logic [31:0] key;
		logic [3:0]  ttl;
	} entry_t;

	typedef struct packed {
		logic        done;
		logic        load;
		logic [31:0] key;
		logic [3:0]  ttl;
	} commit_t;

endpackage

// File: hdl/beacon_presence_ttl_table.sv
// ----------------------------------------------------------------------------
// Beacon presence table with time-to-live aging
// A ring of entry cells rotated past one processing point by a controller.
// ----------------------------------------------------------------------------
// A request is taken at a rising clock edge where start is high and busy is
// low. Scan start ages all live entries, an advertisement refreshes or
// inserts a beacon, and scan end removes expired entries.
// Requests that do no work (a bad advertisement or an unused type) are taken
// and leave busy low. Any other request rotates the whole table once past the
// head cell, one entry per cycle, then passes through a finishing state; busy
// stays high through both, and the length of the rotation sets how often a new
// request can follow. Each event appears for one cycle with result_valid high.
// A left event is held until the next expired entry reaches the head and
// appears in the cycle after that. The final event of a request carries
// last_event and appears in the cycle after the finishing state, when busy is
// already low. The receiver cannot stall the block, so it must take every
// event. The time-to-live reload is written through cfg_valid/cfg_ready; the
// user must do so only while idle, as the block does not enforce it.
// cfg_ready is always high. Reset empties the table and sets the reload to 3.
// ----------------------------------------------------------------------------
module beacon_presence_ttl_table #(
	parameter int TABLE_ENTRIES = bptt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [4:0]  adv_length,
	input  logic [31:0] adv_header,
	input  logic [15:0] beacon_major,
	input  logic [15:0] beacon_minor,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_ttl_reload,
	output logic        result_valid,
	output logic [1:0]  event_kind,
	output logic [15:0] event_major,
	output logic [15:0] event_minor,
	output logic        last_event
);
	import bptt_pkg::*;

	entry_t  ent [TABLE_ENTRIES];
	entry_t  feed;
	logic    shift;
	commit_t commit;

	bptt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.adv_length    (adv_length),
		.adv_header    (adv_header),
		.beacon_major  (beacon_major),
		.beacon_minor  (beacon_minor),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_ttl_reload(cfg_ttl_reload),
		.tail          (ent[0]),
		.feed          (feed),
		.shift         (shift),
		.commit        (commit),
		.result_valid  (result_valid),
		.event_kind    (event_kind),
		.event_major   (event_major),
		.event_minor   (event_minor),
		.last_event    (last_event)
	);

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		entry_t nxt;
		if (i == TABLE_ENTRIES - 1) begin : g_end
			assign nxt = feed;
		end else begin : g_mid
			assign nxt = ent[i+1];
		end
		bptt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.nxt   (nxt),
			.commit(commit),
			.entry (ent[i])
		);
	end

endmodule

// File: hdl/bptt_cell.sv
// ----------------------------------------------------------------------------
// Beacon presence table cell
// Holds one table entry and hands it to its neighbor when the ring rotates.
// ----------------------------------------------------------------------------
module bptt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  bptt_pkg::entry_t  nxt,
	input  bptt_pkg::commit_t commit,
	output bptt_pkg::entry_t  entry
);
	import bptt_pkg::*;

	logic        valid_q;
	logic        pick_q;
	logic [31:0] key_q;
	logic [3:0]  ttl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pick_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt.valid;
			pick_q  <= nxt.pick;
		end else if (commit.done) begin
			if (commit.load && pick_q) begin
				valid_q <= 1'b1;
			end
			pick_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= nxt.key;
			ttl_q <= nxt.ttl;
		end else if (commit.done && commit.load && pick_q) begin
			key_q <= commit.key;
			ttl_q <= commit.ttl;
		end
	end

	assign entry = '{valid: valid_q, pick: pick_q, key: key_q, ttl: ttl_q};

endmodule

// File: hdl/bptt_ctrl.sv
// ----------------------------------------------------------------------------
// Beacon presence table controller
// Sequences the ring rotation, processes the entry leaving the ring head and
// registers the resulting events.
// ----------------------------------------------------------------------------
module bptt_ctrl #(
	parameter int TABLE_ENTRIES = bptt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [4:0]        adv_length,
	input  logic [31:0]       adv_header,
	input  logic [15:0]       beacon_major,
	input  logic [15:0]       beacon_minor,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_ttl_reload,
	input  bptt_pkg::entry_t  tail,
	output bptt_pkg::entry_t  feed,
	output logic              shift,
	output bptt_pkg::commit_t commit,
	output logic              result_valid,
	output logic [1:0]        event_kind,
	output logic [15:0]       event_major,
	output logic [15:0]       event_minor,
	output logic              last_event
);
	import bptt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [IDX_W-1:0] cnt_q;
	req_t            op_q;
	logic [31:0]     key_q;
	logic [3:0]      reload_q;
	logic            hit_q;
	logic            free_q;
	logic [RM_W-1:0] rm_cnt_q;
	logic            pend_valid_q;
	logic [31:0]     pend_key_q;
	logic            res_valid_q;
	kind_t           res_kind_q;
	logic [31:0]     res_key_q;
	logic            res_last_q;

	logic accept;
	logic work;
	logic is_hit;
	logic is_free;
	logic is_expired;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign shift     = (state_q == ST_WALK);

	always_comb begin
		unique case (req_t'(req_type))
			REQ_SCAN_START, REQ_SCAN_END: work = 1'b1;
			REQ_ADVERT:   work = (adv_length == ADV_LEN) && (adv_header == ADV_MAGIC);
			default:      work = 1'b0;
		endcase
	end

	assign is_hit     = (op_q == REQ_ADVERT) && tail.valid && !hit_q && (tail.key == key_q);
	assign is_free    = (op_q == REQ_ADVERT) && !tail.valid && !free_q;
	assign is_expired = (op_q == REQ_SCAN_END) && tail.valid && (tail.ttl == 4'd0)
		&& (rm_cnt_q < RM_W'(RESULT_LIMIT));

	always_comb begin
		feed = tail;
		if ((op_q == REQ_SCAN_START) && tail.valid && (tail.ttl != 4'd0)) begin
			feed.ttl = tail.ttl - 4'd1;
		end
		if (is_hit) begin
			feed.ttl = reload_q;
		end
		if (is_free) begin
			feed.pick = 1'b1;
		end
		if (is_expired) begin
			feed.valid = 1'b0;
		end
	end

	always_comb begin
		commit.done = (state_q == ST_FINISH);
		commit.load = (state_q == ST_FINISH) && (op_q == REQ_ADVERT) && !hit_q && free_q;
		commit.key  = key_q;
		commit.ttl  = reload_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			op_q         <= REQ_SCAN_START;
			reload_q     <= TTL_DEFAULT;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			rm_cnt_q     <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				reload_q <= cfg_ttl_reload;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && work) begin
						state_q      <= ST_WALK;
						cnt_q        <= '0;
						op_q         <= req_t'(req_type);
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						rm_cnt_q     <= '0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (is_hit) begin
						hit_q <= 1'b1;
					end
					if (is_free) begin
						free_q <= 1'b1;
					end
					if (is_expired) begin
						rm_cnt_q     <= rm_cnt_q + RM_W'(1);
						pend_valid_q <= 1'b1;
						if (pend_valid_q) begin
							res_valid_q <= 1'b1;
							res_kind_q  <= EV_LEFT;
							res_key_q   <= pend_key_q;
							res_last_q  <= 1'b0;
						end
					end
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					if (op_q == REQ_ADVERT && !hit_q) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= free_q ? EV_ENTERED : EV_DROPPED;
						res_key_q   <= key_q;
						res_last_q  <= 1'b1;
					end else if (op_q == REQ_SCAN_END && pend_valid_q) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= EV_LEFT;
						res_key_q   <= pend_key_q;
						res_last_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && work) begin
			key_q <= {beacon_major, beacon_minor};
		end
		if (state_q == ST_WALK && is_expired) begin
			pend_key_q <= tail.key;
		end
	end

	assign result_valid = res_valid_q;
	assign event_kind   = res_kind_q;
	assign event_major  = res_key_q[31:16];
	assign event_minor  = res_key_q[15:0];
	assign last_event   = res_last_q;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Beacon presence table testbench
// Drives scan and advertisement requests into the presence table, predicts the
// entered, left and dropped events from its own copy of the table, and checks
// every event against the oldest prediction. Sender idling varies by phase and
// the reload value is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bptt_pkg::*;

	localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] major;
		logic [15:0] minor;
		logic        is_last;
	} beacon_event_t;

	class presence_tracker;
		bit            live[TABLE_ENTRIES];
		logic [31:0]   keys[TABLE_ENTRIES];
		logic [3:0]    ttls[TABLE_ENTRIES];
		logic [3:0]    reload;
		beacon_event_t pending_events[$];
		int            mismatches;

		function new();
			reload = TTL_DEFAULT;
			mismatches = 0;
			foreach (live[i]) live[i] = 1'b0;
		endfunction

		function int pending_count();
			return pending_events.size();
		endfunction

		function void take_request(req_t req, logic [4:0] len, logic [31:0] hdr,
				logic [15:0] maj, logic [15:0] mn);
			logic [31:0]   key;
			int            hit;
			int            free_slot;
			int            i;
			beacon_event_t batch[$];
			beacon_event_t ev;
			key = {maj, mn};
			hit = -1;
			free_slot = -1;
			case (req)
				REQ_SCAN_START: begin
					for (i = 0; i < TABLE_ENTRIES; i++)
						if (live[i] && ttls[i] != 4'd0)
							ttls[i] = ttls[i] - 4'd1;
				end
				REQ_ADVERT: begin
					if (len == ADV_LEN && hdr == ADV_MAGIC) begin
						for (i = 0; i < TABLE_ENTRIES; i++) begin
							if (live[i]) begin
								if (hit < 0 && keys[i] == key)
									hit = i;
							end else if (free_slot < 0) begin
								free_slot = i;
							end
						end
						if (hit >= 0) begin
							ttls[hit] = reload;
						end else if (free_slot >= 0) begin
							live[free_slot] = 1'b1;
							keys[free_slot] = key;
							ttls[free_slot] = reload;
							batch.push_back(beacon_event_t'({EV_ENTERED, key, 1'b0}));
						end else begin
							batch.push_back(beacon_event_t'({EV_DROPPED, key, 1'b0}));
						end
					end
				end
				REQ_SCAN_END: begin
					for (i = 0; i < TABLE_ENTRIES && batch.size() < RESULT_LIMIT; i++) begin
						if (live[i] && ttls[i] == 4'd0) begin
							live[i] = 1'b0;
							batch.push_back(beacon_event_t'({EV_LEFT, keys[i], 1'b0}));
						end
					end
				end
				default: ;
			endcase
			for (i = 0; i < batch.size(); i++) begin
				ev = batch[i];
				ev.is_last = (i == batch.size() - 1);
				pending_events.push_back(ev);
			end
		endfunction

		function void match_event(kind_t k, logic [15:0] maj, logic [15:0] mn, logic fin);
			beacon_event_t want;
			if (pending_events.size() == 0) begin
				$error("unexpected event: kind %0d major %0h minor %0h last %0b",
					k, maj, mn, fin);
				mismatches++;
				return;
			end
			want = pending_events.pop_front();
			if (want.kind !== k) begin
				$error("event_kind: expected %0d, actual %0d", want.kind, k);
				mismatches++;
			end
			if (want.major !== maj) begin
				$error("event_major: expected %0h, actual %0h", want.major, maj);
				mismatches++;
			end
			if (want.minor !== mn) begin
				$error("event_minor: expected %0h, actual %0h", want.minor, mn);
				mismatches++;
			end
			if (want.is_last !== fin) begin
				$error("last_event: expected %0b, actual %0b", want.is_last, fin);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = REQ_SCAN_START;
	logic [4:0]  adv_length = 5'd0;
	logic [31:0] adv_header = 32'd0;
	logic [15:0] beacon_major = 16'd0;
	logic [15:0] beacon_minor = 16'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_ttl_reload = TTL_DEFAULT;
	logic        result_valid;
	logic [1:0]  event_kind;
	logic [15:0] event_major;
	logic [15:0] event_minor;
	logic        last_event;

	presence_tracker tracker;
	int              sender_idle_pct = 0;
	logic [31:0]     key_pool[$];
	int unsigned     cycle_count = 0;

	beacon_presence_ttl_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.adv_length(adv_length),
		.adv_header(adv_header),
		.beacon_major(beacon_major),
		.beacon_minor(beacon_minor),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_ttl_reload(cfg_ttl_reload),
		.result_valid(result_valid),
		.event_kind(event_kind),
		.event_major(event_major),
		.event_minor(event_minor),
		.last_event(last_event)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("beacon_presence_ttl_table verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			tracker.match_event(kind_t'(event_kind), event_major, event_minor, last_event);
	end

	task automatic send_request(input req_t req, input logic [4:0] len,
			input logic [31:0] hdr, input logic [15:0] maj, input logic [15:0] mn);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		adv_length <= len;
		adv_header <= hdr;
		beacon_major <= maj;
		beacon_minor <= mn;
		do begin
			@(posedge clk);
		end while (busy);
		tracker.take_request(req, len, hdr, maj, mn);
	endtask

	task automatic send_advert(input logic [31:0] key);
		send_request(REQ_ADVERT, ADV_LEN, ADV_MAGIC, key[31:16], key[15:0]);
	endtask

	task automatic send_scan(input req_t req);
		send_request(req, 5'($urandom_range(31)), $urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (busy || tracker.pending_count() != 0);
		repeat (TABLE_ENTRIES + 4) @(posedge clk);
	endtask

	task automatic write_reload(input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_ttl_reload <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.reload = value;
	endtask

	task automatic run_segment(input int target);
		int          counted;
		int          variant;
		logic [4:0]  len;
		logic [31:0] hdr;
		counted = 0;
		while (counted < target) begin
			if ($urandom_range(99) < 5)
				send_scan(REQ_UNUSED);
			if ($urandom_range(99) >= 8) begin
				send_scan(REQ_SCAN_START);
				counted++;
			end
			repeat ($urandom_range(6)) begin
				if ($urandom_range(99) < 12) begin
					variant = $urandom_range(2);
					case (variant)
						0: begin
							len = 5'($urandom_range(31));
							if (len == ADV_LEN)
								len = ~ADV_LEN;
							hdr = ADV_MAGIC;
						end
						1: begin
							len = ADV_LEN;
							hdr = ADV_MAGIC ^ (32'd1 << $urandom_range(31));
						end
						default: begin
							len = 5'($urandom_range(31));
							hdr = $urandom;
						end
					endcase
					send_request(REQ_ADVERT, len, hdr, 16'($urandom), 16'($urandom));
				end else begin
					send_advert(key_pool[$urandom_range(key_pool.size() - 1)]);
					counted++;
				end
			end
			if ($urandom_range(99) >= 8) begin
				send_scan(REQ_SCAN_END);
				counted++;
			end
		end
	endtask

	initial begin
		int         seg;
		int         i;
		logic [3:0] plan[6];
		tracker = new();
		plan[0] = 4'd15;
		plan[1] = 4'd0;
		plan[2] = 4'd2;
		plan[3] = 4'($urandom_range(15));
		plan[4] = 4'd1;
		plan[5] = 4'($urandom_range(1, 15));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 34;
		send_scan(REQ_SCAN_END);
		send_request(REQ_UNUSED, ADV_LEN, ADV_MAGIC, 16'h1234, 16'h5678);
		send_request(REQ_ADVERT, 5'd24, ADV_MAGIC, 16'h1234, 16'h5678);
		send_request(REQ_ADVERT, ADV_LEN, 32'h4C00_0216, 16'h1234, 16'h5678);
		send_advert(32'h0000_0000);
		wait_idle();
		write_reload(4'd1);
		send_advert(32'h0000_0000);
		for (i = 1; i < TABLE_ENTRIES; i++)
			send_advert(i == TABLE_ENTRIES - 1 ? 32'hFFFF_FFFF : {16'(i), 16'hA5A5 ^ 16'(i)});
		send_advert(32'h8000_0001);
		send_scan(REQ_SCAN_START);
		send_scan(REQ_SCAN_START);
		send_scan(REQ_SCAN_END);

		for (seg = 0; seg < 6; seg++) begin
			wait_idle();
			write_reload(plan[seg]);
			sender_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 72 : 0;
			key_pool.delete();
			key_pool.push_back(32'h0000_0000);
			key_pool.push_back(32'hFFFF_FFFF);
			repeat ($urandom_range(4, 26))
				key_pool.push_back($urandom);
			run_segment(73);
		end
		wait_idle();

		if (tracker.mismatches == 0 && tracker.pending_count() == 0)
			$display("beacon_presence_ttl_table verification clean");
		else
			$display("beacon_presence_ttl_table verification failed");
		$finish;
	end

endmodule

// File: files.f
hdl/bptt_pkg.sv
hdl/bptt_cell.sv
hdl/bptt_ctrl.sv
hdl/beacon_presence_ttl_table.sv
verif/testbench.sv
